[hdl/cst_pkg.sv]
// shared types, codes and helpers for the call state table
// no dependencies; used by the interfaces, the result queue and the top level
package cst_pkg;

    localparam int FUNC_W   = 3;
    localparam int UNIT_W   = 6;
    localparam int NOTICE_W = 3;

    // event codes
    localparam logic [FUNC_W-1:0] FN_REGISTER = 3'd0;
    localparam logic [FUNC_W-1:0] FN_PICKUP   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_HANGUP   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_DIAL     = 3'd3;
    localparam logic [FUNC_W-1:0] FN_CHAT     = 3'd4;

    // line states, also notice codes
    localparam logic [NOTICE_W-1:0] NT_ON_HOOK   = 3'd0;
    localparam logic [NOTICE_W-1:0] NT_RINGING   = 3'd1;
    localparam logic [NOTICE_W-1:0] NT_DIAL_TONE = 3'd2;
    localparam logic [NOTICE_W-1:0] NT_RING_BACK = 3'd3;
    localparam logic [NOTICE_W-1:0] NT_CONNECTED = 3'd4;
    localparam logic [NOTICE_W-1:0] NT_ERROR     = 3'd5;
    localparam logic [NOTICE_W-1:0] NT_BUSY      = 3'd6;
    localparam logic [NOTICE_W-1:0] NT_CHAT      = 3'd7;

    // one table entry
    typedef struct packed {
        logic                registered;
        logic [UNIT_W-1:0]   peer;
        logic [NOTICE_W-1:0] line;
    } t_entry;

    // one notice
    typedef struct packed {
        logic [UNIT_W-1:0]   dest_unit;
        logic [NOTICE_W-1:0] notice;
        logic                status;
        logic                last;
    } t_result;

    // notices handed to the result queue in one cycle
    typedef struct packed {
        logic [1:0] cnt;
        t_result    a;
        t_result    b;
    } t_push;

    function automatic t_result mk_res(logic [UNIT_W-1:0] dest, logic [NOTICE_W-1:0] nt,
                                       logic st, logic lst);
        t_result r;
        r.dest_unit = dest;
        r.notice    = nt;
        r.status    = st;
        r.last      = lst;
        return r;
    endfunction

endpackage

[hdl/cst_if.sv]
// request and notice channels of the call state table
// depends on cst_pkg for field widths
interface cst_in_if;
    logic                             valid;
    logic                             ready;
    logic [cst_pkg::FUNC_W-1:0]       func;
    logic [cst_pkg::UNIT_W-1:0]       unit;
    logic [cst_pkg::UNIT_W-1:0]       target_unit;
    logic                             target_given;

    modport source (output valid, func, unit, target_unit, target_given, input ready);
    modport sink   (input valid, func, unit, target_unit, target_given, output ready);
endinterface

interface cst_out_if;
    logic                             valid;
    logic                             ready;
    logic [cst_pkg::UNIT_W-1:0]       dest_unit;
    logic [cst_pkg::NOTICE_W-1:0]     notice;
    logic                             status;
    logic                             last;

    modport source (output valid, dest_unit, notice, status, last, input ready);
    modport sink   (input valid, dest_unit, notice, status, last, output ready);
endinterface

[hdl/call_state_table.sv]
// call state table: keeps UNITS telephone units, each with a registered flag,
// a line state and a peer, in one single-port table memory with a registered
// read. An event touching only its own unit reads it, then writes it back; an
// event that also touches the peer or dialed target reads the unit, reads the
// partner, writes the unit and writes the partner, all serialized on the one
// table port, except a dial whose target turns out unregistered or not on
// hook, which writes the unit back as busy and ends there. Notices go to a
// four-deep queue, so a new request is taken while earlier notices wait, as
// long as the queue holds two or fewer. After reset a clearing pass writes
// every entry to zero, during which no request is taken.
// depends on cst_pkg, cst_if and cst_res_fifo
module call_state_table #(
    parameter int UNITS = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cst_in_if.sink     i_req,
    cst_out_if.source  o_res
);

    localparam int AW = $clog2(UNITS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(UNITS - 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_UNIT  = 3'd2;  // unit entry on read port
    localparam logic [2:0] S_PART  = 3'd3;  // partner entry on read port
    localparam logic [2:0] S_WB    = 3'd4;  // partner write back

    // table memory
    cst_pkg::t_entry mem [UNITS];
    cst_pkg::t_entry r_rdata;
    logic            mem_we;
    logic [AW-1:0]   mem_addr;
    cst_pkg::t_entry mem_wdata;

    logic [2:0]                  r_state, n_state;
    logic [AW-1:0]               r_clr_addr;
    logic [cst_pkg::FUNC_W-1:0]  r_func;
    logic [cst_pkg::UNIT_W-1:0]  r_unit;
    logic [cst_pkg::UNIT_W-1:0]  r_tgt;
    logic                        r_given;
    cst_pkg::t_entry             r_uw, n_uw;         // unit entry kept across partner read
    logic [AW-1:0]               r_w2_addr, n_w2_addr;
    cst_pkg::t_entry             r_w2_data, n_w2_data;

    cst_pkg::t_push push;
    logic           room;
    logic           accept;
    logic           unit_ok;
    logic           tgt_ok;

    assign i_req.ready = (r_state == S_IDLE) && room;
    assign accept      = i_req.valid && i_req.ready;
    assign unit_ok     = (32'(r_unit) < 32'(UNITS));
    assign tgt_ok      = (32'(r_tgt) < 32'(UNITS)) && (r_tgt != r_unit);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        r_rdata <= mem[mem_addr];
    end

    always_comb begin
        cst_pkg::t_entry uw;
        cst_pkg::t_entry vw;
        cst_pkg::t_entry ew;
        logic [cst_pkg::NOTICE_W-1:0] ps;

        uw        = r_rdata;
        vw        = r_rdata;
        ew        = r_uw;
        ps        = cst_pkg::NT_DIAL_TONE;
        mem_we    = 1'b0;
        mem_addr  = AW'(r_unit);
        mem_wdata = r_uw;
        push      = '0;
        n_state   = r_state;
        n_uw      = r_uw;
        n_w2_addr = r_w2_addr;
        n_w2_data = r_w2_data;

        unique case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_addr  = r_clr_addr;
                mem_wdata = '0;
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                // read the acting unit as the request is taken
                mem_addr = AW'(i_req.unit);
                if (accept) begin
                    n_state = S_UNIT;
                end
            end
            S_UNIT: begin
                n_uw     = uw;
                n_state  = S_IDLE;
                push.cnt = 2'd1;
                push.a   = cst_pkg::mk_res(r_unit, uw.line, 1'b0, 1'b1);
                ew       = uw;
                if (r_func > cst_pkg::FN_CHAT || !unit_ok) begin
                    push.a = cst_pkg::mk_res(r_unit, cst_pkg::NT_ERROR, 1'b1, 1'b1);
                end else if (r_func != cst_pkg::FN_REGISTER && !uw.registered) begin
                    push.a.status = 1'b1;
                end else begin
                    unique case (r_func)
                        cst_pkg::FN_REGISTER: begin
                            ew.registered = 1'b1;
                            mem_we        = 1'b1;
                            mem_wdata     = ew;
                        end
                        cst_pkg::FN_PICKUP: begin
                            if (uw.line == cst_pkg::NT_ON_HOOK) begin
                                ew.line     = cst_pkg::NT_DIAL_TONE;
                                mem_we      = 1'b1;
                                mem_wdata   = ew;
                                push.a.notice = cst_pkg::NT_DIAL_TONE;
                            end else if (uw.line == cst_pkg::NT_RINGING) begin
                                push.cnt = 2'd0;
                                mem_addr = AW'(uw.peer);
                                n_state  = S_PART;
                            end
                        end
                        cst_pkg::FN_HANGUP: begin
                            if (uw.line == cst_pkg::NT_CONNECTED ||
                                uw.line == cst_pkg::NT_RINGING ||
                                uw.line == cst_pkg::NT_RING_BACK) begin
                                push.cnt = 2'd0;
                                mem_addr = AW'(uw.peer);
                                n_state  = S_PART;
                            end else begin
                                ew.line       = cst_pkg::NT_ON_HOOK;
                                mem_we        = 1'b1;
                                mem_wdata     = ew;
                                push.a.notice = cst_pkg::NT_ON_HOOK;
                            end
                        end
                        cst_pkg::FN_DIAL: begin
                            if (uw.line != cst_pkg::NT_DIAL_TONE) begin
                                push.a.notice = uw.line;
                            end else if (!r_given) begin
                                ew.line   = cst_pkg::NT_ERROR;
                                mem_we    = 1'b1;
                                mem_wdata = ew;
                                push.a    = cst_pkg::mk_res(r_unit, cst_pkg::NT_ERROR,
                                                            1'b1, 1'b1);
                            end else if (!tgt_ok) begin
                                ew.line       = cst_pkg::NT_BUSY;
                                mem_we        = 1'b1;
                                mem_wdata     = ew;
                                push.a.notice = cst_pkg::NT_BUSY;
                            end else begin
                                // need the target's flag and state
                                push.cnt = 2'd0;
                                mem_addr = AW'(r_tgt);
                                n_state  = S_PART;
                            end
                        end
                        cst_pkg::FN_CHAT: begin
                            if (uw.line == cst_pkg::NT_CONNECTED) begin
                                push.cnt = 2'd2;
                                push.a   = cst_pkg::mk_res(r_unit, cst_pkg::NT_CONNECTED,
                                                           1'b0, 1'b0);
                                push.b   = cst_pkg::mk_res(uw.peer, cst_pkg::NT_CHAT,
                                                           1'b0, 1'b1);
                            end else begin
                                push.a.status = 1'b1;
                            end
                        end
                        default: begin
                            push.a = cst_pkg::mk_res(r_unit, cst_pkg::NT_ERROR, 1'b1, 1'b1);
                        end
                    endcase
                end
            end
            S_PART: begin
                // partner entry now on the read port; write the unit back
                mem_we   = 1'b1;
                mem_addr = AW'(r_unit);
                n_state  = S_WB;
                vw       = r_rdata;
                ew       = r_uw;
                push.cnt = 2'd2;
                case (r_func)
                    cst_pkg::FN_PICKUP: begin
                        ew.line        = cst_pkg::NT_CONNECTED;
                        n_w2_addr      = AW'(r_uw.peer);
                        n_w2_data      = vw;
                        n_w2_data.line = cst_pkg::NT_CONNECTED;
                        push.a = cst_pkg::mk_res(r_unit, cst_pkg::NT_CONNECTED, 1'b0, 1'b0);
                        push.b = cst_pkg::mk_res(r_uw.peer, cst_pkg::NT_CONNECTED,
                                                 1'b0, 1'b1);
                    end
                    cst_pkg::FN_HANGUP: begin
                        ps = (r_uw.line == cst_pkg::NT_RING_BACK) ? cst_pkg::NT_ON_HOOK
                                                                 : cst_pkg::NT_DIAL_TONE;
                        ew.line        = cst_pkg::NT_ON_HOOK;
                        ew.peer        = '0;
                        n_w2_addr      = AW'(r_uw.peer);
                        n_w2_data      = vw;
                        n_w2_data.line = ps;
                        n_w2_data.peer = '0;
                        push.a = cst_pkg::mk_res(r_unit, cst_pkg::NT_ON_HOOK, 1'b0, 1'b0);
                        push.b = cst_pkg::mk_res(r_uw.peer, ps, 1'b0, 1'b1);
                    end
                    default: begin
                        // dial with a candidate target
                        if (!vw.registered || vw.line != cst_pkg::NT_ON_HOOK) begin
                            ew.line  = cst_pkg::NT_BUSY;
                            push.cnt = 2'd1;
                            push.a   = cst_pkg::mk_res(r_unit, cst_pkg::NT_BUSY, 1'b0, 1'b1);
                            n_state  = S_IDLE;
                        end else begin
                            ew.line        = cst_pkg::NT_RING_BACK;
                            ew.peer        = r_tgt;
                            n_w2_addr      = AW'(r_tgt);
                            n_w2_data      = vw;
                            n_w2_data.line = cst_pkg::NT_RINGING;
                            n_w2_data.peer = r_unit;
                            push.a = cst_pkg::mk_res(r_unit, cst_pkg::NT_RING_BACK,
                                                     1'b0, 1'b0);
                            push.b = cst_pkg::mk_res(r_tgt, cst_pkg::NT_RINGING, 1'b0, 1'b1);
                        end
                    end
                endcase
                mem_wdata = ew;
            end
            S_WB: begin
                mem_we    = 1'b1;
                mem_addr  = r_w2_addr;
                mem_wdata = r_w2_data;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // request capture and working registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func  <= i_req.func;
            r_unit  <= i_req.unit;
            r_tgt   <= i_req.target_unit;
            r_given <= i_req.target_given;
        end
        r_uw      <= n_uw;
        r_w2_addr <= n_w2_addr;
        r_w2_data <= n_w2_data;
    end

    // control state and clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    cst_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_res   (o_res)
    );

endmodule

[hdl/cst_res_fifo.sv]
// four-deep notice queue, takes up to two notices a cycle
// depends on cst_pkg and cst_out_if
module cst_res_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  cst_pkg::t_push  i_push,
    output logic            o_room,
    cst_out_if.source       o_res
);

    cst_pkg::t_result r_buf [4];
    logic [1:0]       r_head;
    logic [1:0]       r_tail;
    logic [2:0]       r_cnt;
    logic             pop;
    logic [1:0]       tail_b;

    assign pop    = o_res.valid && o_res.ready;
    assign tail_b = r_tail + 2'd1;
    // room for a whole event's notices
    assign o_room = (r_cnt <= 3'd2);

    assign o_res.valid     = (r_cnt != 3'd0);
    assign o_res.dest_unit = r_buf[r_head].dest_unit;
    assign o_res.notice    = r_buf[r_head].notice;
    assign o_res.status    = r_buf[r_head].status;
    assign o_res.last      = r_buf[r_head].last;

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_buf[r_tail] <= i_push.a;
        end
        if (i_push.cnt == 2'd2) begin
            r_buf[tail_b] <= i_push.b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_cnt  <= '0;
        end else begin
            r_tail <= r_tail + i_push.cnt;
            if (pop) begin
                r_head <= r_head + 2'd1;
            end
            r_cnt <= r_cnt + {1'b0, i_push.cnt} - {2'b0, pop};
        end
    end

endmodule
